// File: rtl/nfsa_pkg.sv
// shared constants, codes and control types of the next-fit slot allocator
package nfsa_pkg;

    // pool geometry
    localparam int MAX_SLOTS  = 1024;
    localparam int IDX_W      = $clog2(MAX_SLOTS);
    localparam int COUNT_W    = IDX_W + 1;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int NUM_WORDS  = MAX_SLOTS / WORD_W;
    localparam int WADDR_W    = $clog2(NUM_WORDS);

    // field widths
    localparam int STRIDE_W   = 13;
    localparam int ADDR_W     = 64;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int PROD_W     = COUNT_W + STRIDE_W;
    localparam int DIV_CNT_W  = $clog2(IDX_W);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE     = 2'd2;

    localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(MAX_SLOTS);
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);

    // request function codes
    localparam logic [FUNC_W-1:0] FN_ALLOC_IDX  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC_ADDR = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FREE_IDX   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FREE_ADDR  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd4;

    // response status codes
    localparam logic [STATUS_W-1:0] RS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] RS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] RS_RANGE   = 2'd2;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DIV_START,
        S_DIV_WAIT,
        S_FREE_RD,
        S_FREE_WR,
        S_MUL,
        S_ADD,
        S_DONE
    } state_t;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_SETUP,
        DP_SCAN_RD,
        DP_SCAN_CHK,
        DP_FREE_RD,
        DP_FREE_WR,
        DP_DIV_START,
        DP_DIV_TAKE,
        DP_MUL,
        DP_RES_OK,
        DP_RES_NOFREE,
        DP_RES_RANGE,
        DP_RES_ZERO,
        DP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic is_free_idx;
        logic is_free_addr;
        logic is_clear;
        logic idx_range_err;
        logic addr_range_err;
        logic found;
        logic exhausted;
        logic div_busy;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/nfsa_if.sv
// request and response channel interfaces
interface nfsa_req_if import nfsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [IDX_W-1:0]    slot_index;
    logic [ADDR_W-1:0]   handle_address;

    modport source (output valid, output func, output slot_index, output handle_address,
                    input ready);
    modport sink   (input valid, input func, input slot_index, input handle_address,
                    output ready);
endinterface

interface nfsa_rsp_if import nfsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_index;
    logic [ADDR_W-1:0]   granted_address;

    modport source (output valid, output status, output granted_index,
                    output granted_address, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input granted_address, output ready);
endinterface

// File: rtl/nfsa_ram.sv
// generic single-write, single-read ram with registered read data
module nfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/nfsa_div.sv
// restoring divider, one quotient bit per cycle, for address to index conversion
module nfsa_div import nfsa_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROD_W-1:0]   dividend,
    input  logic [STRIDE_W-1:0] divisor,
    output logic                busy,
    output logic [IDX_W-1:0]    quotient
);

    logic                 busy_reg, busy_next;
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]     q_reg, q_next;
    logic [DIV_CNT_W-1:0] pos_reg, pos_next;
    logic [PROD_W-1:0]    shifted;
    logic                 fits;

    // trial subtraction of the divisor at the current bit position
    assign shifted = PROD_W'(divisor) << pos_reg;
    assign fits    = rem_reg >= shifted;

    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        pos_next  = pos_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = dividend;
            q_next    = '0;
            pos_next  = DIV_CNT_W'(IDX_W - 1);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next       = rem_reg - shifted;
                q_next[pos_reg] = 1'b1;
            end
            if (pos_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        pos_reg <= pos_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// File: rtl/nfsa_dp.sv
// datapath: configuration, bitmap store, word scan, divider and result registers
module nfsa_dp import nfsa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [FUNC_W-1:0]     in_func,
    input  logic [IDX_W-1:0]      in_slot_index,
    input  logic [ADDR_W-1:0]     in_handle_address,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [STATUS_W-1:0]   out_status,
    output logic [IDX_W-1:0]      out_index,
    output logic [ADDR_W-1:0]     out_address
);

    // configuration
    logic [COUNT_W-1:0]  slot_count_reg, slot_count_next;
    logic [ADDR_W-1:0]   heap_base_reg, heap_base_next;
    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic [COUNT_W-1:0]  eff_count;
    logic [STRIDE_W-1:0] eff_stride;

    // captured request
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [IDX_W-1:0]    sidx_reg, sidx_next;
    logic [ADDR_W-1:0]   haddr_reg, haddr_next;

    // allocator state
    logic [IDX_W-1:0]     last_reg, last_next;
    logic [NUM_WORDS-1:0] valid_reg, valid_next;

    // working registers
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [WADDR_W-1:0]  waddr_reg, waddr_next;
    logic                phase_reg, phase_next;
    logic [IDX_W-1:0]    tgt_reg, tgt_next;
    logic [ADDR_W-1:0]   diff_reg, diff_next;
    logic [PROD_W-1:0]   lim_reg, lim_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [IDX_W-1:0]    out_idx_reg, out_idx_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;

    // scan and store signals
    logic [COUNT_W-1:0]  next_pos;
    logic [IDX_W-1:0]    start_calc;
    logic [COUNT_W-1:0]  count_m1;
    logic [WADDR_W-1:0]  last_word;
    logic [BIT_W-1:0]    last_bit;
    logic [WADDR_W-1:0]  start_word;
    logic [BIT_W-1:0]    start_bit;
    logic [WADDR_W-1:0]  tgt_word;
    logic [WADDR_W-1:0]  word_sel;
    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   word_eff;
    logic [WORD_W-1:0]   lo_mask;
    logic [WORD_W-1:0]   hi_mask;
    logic [WORD_W-1:0]   scan_mask;
    logic [WORD_W-1:0]   cand;
    logic [WORD_W-1:0]   low_onehot;
    logic [BIT_W-1:0]    found_bit;
    logic [IDX_W-1:0]    found_idx;
    logic                at_last;
    logic                at_start;
    logic                found;
    logic                exhausted;
    logic                ram_we;
    logic                ram_re;
    logic [WADDR_W-1:0]  ram_raddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                div_busy;
    logic [IDX_W-1:0]    div_q;

    // effective count and stride
    always_comb
    begin
        if (slot_count_reg == '0)
        begin
            eff_count = COUNT_W'(1);
        end
        else if (slot_count_reg > COUNT_W'(MAX_SLOTS))
        begin
            eff_count = COUNT_W'(MAX_SLOTS);
        end
        else
        begin
            eff_count = slot_count_reg;
        end
    end

    assign eff_stride = (stride_reg == '0) ? STRIDE_W'(1) : stride_reg;

    // configuration writes
    always_comb
    begin
        slot_count_next = slot_count_reg;
        heap_base_next  = heap_base_reg;
        stride_next     = stride_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLOT_COUNT: slot_count_next = cfg_data[COUNT_W-1:0];
                CFG_HEAP_BASE:  heap_base_next  = cfg_data[ADDR_W-1:0];
                CFG_STRIDE:     stride_next     = cfg_data[STRIDE_W-1:0];
                default:        ;
            endcase
        end
    end

    // search start and word geometry
    assign next_pos   = COUNT_W'(last_reg) + COUNT_W'(1);
    assign start_calc = (next_pos >= eff_count) ? '0 : next_pos[IDX_W-1:0];
    assign count_m1   = eff_count - COUNT_W'(1);
    assign last_word  = count_m1[IDX_W-1:BIT_W];
    assign last_bit   = count_m1[BIT_W-1:0];
    assign start_word = start_reg[IDX_W-1:BIT_W];
    assign start_bit  = start_reg[BIT_W-1:0];
    assign tgt_word   = tgt_reg[IDX_W-1:BIT_W];
    assign word_sel   = (cmd.op == DP_FREE_WR) ? tgt_word : waddr_reg;

    // words never written since clear read as all free
    assign word_eff = valid_reg[word_sel] ? ram_rdata : '0;

    // candidate mask for the word under scan
    assign at_last  = waddr_reg == last_word;
    assign at_start = waddr_reg == start_word;
    assign lo_mask  = at_start ? ({WORD_W{1'b1}} << start_bit) : {WORD_W{1'b1}};
    assign hi_mask  = at_last ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_bit))
                              : {WORD_W{1'b1}};
    assign scan_mask = phase_reg ? (at_start ? ~({WORD_W{1'b1}} << start_bit)
                                             : {WORD_W{1'b1}})
                                 : (lo_mask & hi_mask);
    assign cand       = ~word_eff & scan_mask;
    assign low_onehot = cand & (~cand + WORD_W'(1));
    assign found      = cand != '0;
    assign exhausted  = phase_reg ? at_start : (at_last && (start_reg == '0));

    // encode the lowest free bit
    always_comb
    begin
        found_bit = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            if (low_onehot[b])
            begin
                found_bit = found_bit | BIT_W'(b);
            end
        end
    end

    assign found_idx = {waddr_reg, found_bit};

    // bitmap store access
    assign ram_re    = (cmd.op == DP_SCAN_RD) || (cmd.op == DP_FREE_RD);
    assign ram_raddr = (cmd.op == DP_FREE_RD) ? tgt_word : waddr_reg;
    assign ram_we    = ((cmd.op == DP_SCAN_CHK) && found) || (cmd.op == DP_FREE_WR);
    assign ram_wdata = (cmd.op == DP_FREE_WR)
                     ? (word_eff & ~(WORD_W'(1) << tgt_reg[BIT_W-1:0]))
                     : (word_eff | low_onehot);

    nfsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (word_sel),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nfsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == DP_DIV_START),
        .dividend (diff_reg[PROD_W-1:0]),
        .divisor  (eff_stride),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // per-operation register updates
    always_comb
    begin
        func_next       = func_reg;
        sidx_next       = sidx_reg;
        haddr_next      = haddr_reg;
        last_next       = last_reg;
        valid_next      = valid_reg;
        start_next      = start_reg;
        waddr_next      = waddr_reg;
        phase_next      = phase_reg;
        tgt_next        = tgt_reg;
        diff_next       = diff_reg;
        lim_next        = lim_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_addr_next   = res_addr_reg;
        if (ram_we)
        begin
            valid_next[word_sel] = 1'b1;
        end
        unique case (cmd.op)
            DP_CAPTURE:
            begin
                func_next  = in_func;
                sidx_next  = in_slot_index;
                haddr_next = in_handle_address;
            end
            DP_SETUP:
            begin
                start_next = start_calc;
                waddr_next = start_calc[IDX_W-1:BIT_W];
                phase_next = 1'b0;
                tgt_next   = sidx_reg;
                diff_next  = haddr_reg - heap_base_reg;
                lim_next   = PROD_W'(eff_count) * PROD_W'(eff_stride);
            end
            DP_SCAN_CHK:
            begin
                if (found)
                begin
                    last_next = found_idx;
                    tgt_next  = found_idx;
                end
                else if (!exhausted)
                begin
                    if (!phase_reg && at_last)
                    begin
                        phase_next = 1'b1;
                        waddr_next = '0;
                    end
                    else
                    begin
                        waddr_next = waddr_reg + WADDR_W'(1);
                    end
                end
            end
            DP_DIV_TAKE:
            begin
                tgt_next = div_q;
            end
            DP_MUL:
            begin
                prod_next = PROD_W'(tgt_reg) * PROD_W'(eff_stride);
            end
            DP_RES_OK:
            begin
                res_status_next = RS_OK;
                res_idx_next    = tgt_reg;
                res_addr_next   = heap_base_reg + ADDR_W'(prod_reg);
            end
            DP_RES_NOFREE:
            begin
                res_status_next = RS_NO_FREE;
                res_idx_next    = '0;
                res_addr_next   = '0;
            end
            DP_RES_RANGE:
            begin
                res_status_next = RS_RANGE;
                res_idx_next    = '0;
                res_addr_next   = '0;
            end
            DP_RES_ZERO:
            begin
                res_status_next = RS_OK;
                res_idx_next    = '0;
                res_addr_next   = '0;
            end
            DP_CLEAR:
            begin
                valid_next      = '0;
                last_next       = '0;
                res_status_next = RS_OK;
                res_idx_next    = '0;
                res_addr_next   = '0;
            end
            default: ;
        endcase
    end

    // output register, free again once the beat is taken
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_addr_next   = out_addr_reg;
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_idx_next    = res_idx_reg;
            out_addr_next   = res_addr_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= COUNT_RESET;
            heap_base_reg  <= '0;
            stride_reg     <= STRIDE_RESET;
            last_reg       <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_count_reg <= slot_count_next;
            heap_base_reg  <= heap_base_next;
            stride_reg     <= stride_next;
            last_reg       <= last_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        sidx_reg       <= sidx_next;
        haddr_reg      <= haddr_next;
        start_reg      <= start_next;
        waddr_reg      <= waddr_next;
        phase_reg      <= phase_next;
        tgt_reg        <= tgt_next;
        diff_reg       <= diff_next;
        lim_reg        <= lim_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_addr_reg   <= out_addr_next;
    end

    // status towards the controller
    always_comb
    begin
        stat.is_alloc       = (func_reg == FN_ALLOC_IDX) || (func_reg == FN_ALLOC_ADDR);
        stat.is_free_idx    = func_reg == FN_FREE_IDX;
        stat.is_free_addr   = func_reg == FN_FREE_ADDR;
        stat.is_clear       = func_reg == FN_CLEAR;
        stat.idx_range_err  = COUNT_W'(tgt_reg) >= eff_count;
        stat.addr_range_err = diff_reg >= ADDR_W'(lim_reg);
        stat.found          = found;
        stat.exhausted      = exhausted;
        stat.div_busy       = div_busy;
        stat.out_free       = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_index   = out_idx_reg;
    assign out_address = out_addr_reg;

endmodule

// File: rtl/nfsa_ctrl.sv
// controller state machine sequencing the datapath for one request at a time
module nfsa_ctrl import nfsa_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                priority if (stat.is_alloc)
                begin
                    state_next = S_SCAN_RD;
                end
                else if (stat.is_free_idx)
                begin
                    state_next = stat.idx_range_err ? S_DONE : S_FREE_RD;
                end
                else if (stat.is_free_addr)
                begin
                    state_next = stat.addr_range_err ? S_DONE : S_DIV_START;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                priority if (stat.found)
                begin
                    state_next = S_MUL;
                end
                else if (stat.exhausted)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_FREE_RD;
                end
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd.op       = DP_NOP;
        cmd.out_load = 1'b0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = DP_CAPTURE;
                end
            end
            S_SETUP:
            begin
                cmd.op = DP_SETUP;
            end
            S_DISPATCH:
            begin
                priority if (stat.is_alloc)
                begin
                    cmd.op = DP_NOP;
                end
                else if (stat.is_free_idx)
                begin
                    cmd.op = stat.idx_range_err ? DP_RES_RANGE : DP_NOP;
                end
                else if (stat.is_free_addr)
                begin
                    cmd.op = stat.addr_range_err ? DP_RES_RANGE : DP_NOP;
                end
                else if (stat.is_clear)
                begin
                    cmd.op = DP_CLEAR;
                end
                else
                begin
                    cmd.op = DP_RES_ZERO;
                end
            end
            S_SCAN_RD:
            begin
                cmd.op = DP_SCAN_RD;
            end
            S_SCAN_CHK:
            begin
                cmd.op = (!stat.found && stat.exhausted) ? DP_RES_NOFREE : DP_SCAN_CHK;
            end
            S_DIV_START:
            begin
                cmd.op = DP_DIV_START;
            end
            S_DIV_WAIT:
            begin
                cmd.op = stat.div_busy ? DP_NOP : DP_DIV_TAKE;
            end
            S_FREE_RD:
            begin
                cmd.op = DP_FREE_RD;
            end
            S_FREE_WR:
            begin
                cmd.op = DP_FREE_WR;
            end
            S_MUL:
            begin
                cmd.op = DP_MUL;
            end
            S_ADD:
            begin
                cmd.op = DP_RES_OK;
            end
            S_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/next_fit_slot_allocator.sv
// top level of the next-fit slot allocator: controller, datapath and checks
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    func, slot_index, handle_address
//   rsp      out  valid/ready    status, granted_index, granted_address
//   cfg      in   cfg_we only    cfg_index, cfg_data
//
// one request at a time; the next is taken while a response waits in the output register
// alloc: setup and dispatch, then a registered read and a check per bitmap word, then multiply and add
// free by index reads and rewrites the bitmap word; free by address first runs the bit-serial divider
// clear, unused codes and out-of-range frees go from dispatch to done; clear drops the word valid bits
// reset leaves every slot free with no clearing pass; a stalled rsp holds the block in done
module next_fit_slot_allocator import nfsa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    nfsa_req_if.sink              req,
    nfsa_rsp_if.source            rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing
    nfsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // bitmap, arithmetic and result registers
    nfsa_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_func           (req.func),
        .in_slot_index     (req.slot_index),
        .in_handle_address (req.handle_address),
        .cmd               (cmd),
        .stat              (stat),
        .out_ready         (rsp.ready),
        .out_valid         (rsp.valid),
        .out_status        (rsp.status),
        .out_index         (rsp.granted_index),
        .out_address       (rsp.granted_address)
    );

    // only one request in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in progress");

    // a new result never overwrites an untaken beat
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp.valid || rsp.ready))
        else $error("output register loaded while beat still pending");

    // error responses carry no slot
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != RS_OK))
            |-> ((rsp.granted_index == '0) && (rsp.granted_address == '0)))
        else $error("error response with non-zero slot fields");

endmodule

// File: tb/sv/nfsa_grant_checker.sv
// response checker for the next-fit slot allocator: mirrors the slot pool and compares every beat
module nfsa_grant_checker import nfsa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    nfsa_req_if                   req,
    nfsa_rsp_if                   rsp,
    output int                    fail_count,
    output int                    grants_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
        logic [ADDR_W-1:0]   address;
    } grant_t;

    // mirrored pool state and registers
    logic [MAX_SLOTS-1:0] pool_used;
    logic [IDX_W-1:0]     last_slot;
    logic [COUNT_W-1:0]   reg_count;
    logic [ADDR_W-1:0]    reg_base;
    logic [STRIDE_W-1:0]  reg_stride;

    grant_t grants_due[$];
    grant_t oldest;
    int     mismatches = 0;
    int     pending    = 0;

    assign fail_count     = mismatches;
    assign grants_pending = pending;

    // slot count as the block uses it: zero reads as one, capped at the pool size
    function automatic int live_slots();
        if (reg_count == '0)
            return 1;
        if (reg_count > COUNT_W'(MAX_SLOTS))
            return MAX_SLOTS;
        return int'(reg_count);
    endfunction

    // zero stride reads as one
    function automatic logic [ADDR_W-1:0] step_bytes();
        return (reg_stride == '0) ? ADDR_W'(1) : ADDR_W'(reg_stride);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(int slot);
        return reg_base + ADDR_W'(slot) * step_bytes();
    endfunction

    // expected response for one request, updating the mirrored pool
    function automatic grant_t predict_grant(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] idx,
                                             logic [ADDR_W-1:0] addr);
        grant_t            g;
        int                n;
        int                pos;
        bit                found;
        logic [ADDR_W-1:0] quot;
        g     = '0;
        n     = live_slots();
        found = 1'b0;
        case (func)
            FN_ALLOC_IDX, FN_ALLOC_ADDR:
            begin
                // next-fit: start after the last grant, wrap at the slot count
                pos = int'(last_slot) + 1;
                if (pos >= n)
                    pos = 0;
                for (int k = 0; k < n && !found; k++)
                begin
                    if (!pool_used[pos])
                    begin
                        found          = 1'b1;
                        pool_used[pos] = 1'b1;
                        last_slot      = IDX_W'(pos);
                        g.index        = IDX_W'(pos);
                        g.address      = slot_addr(pos);
                    end
                    else
                    begin
                        pos = (pos + 1 >= n) ? 0 : pos + 1;
                    end
                end
                g.status = found ? RS_OK : RS_NO_FREE;
            end
            FN_FREE_IDX:
            begin
                if (int'(idx) >= n)
                begin
                    g.status = RS_RANGE;
                end
                else
                begin
                    pool_used[idx] = 1'b0;
                    g.status       = RS_OK;
                    g.index        = idx;
                    g.address      = slot_addr(int'(idx));
                end
            end
            FN_FREE_ADDR:
            begin
                // an address below the base wraps to a huge index
                quot = (addr - reg_base) / step_bytes();
                if (quot >= ADDR_W'(n))
                begin
                    g.status = RS_RANGE;
                end
                else
                begin
                    pool_used[int'(quot)] = 1'b0;
                    g.status              = RS_OK;
                    g.index               = IDX_W'(quot);
                    g.address             = slot_addr(int'(quot));
                end
            end
            FN_CLEAR:
            begin
                pool_used = '0;
                last_slot = '0;
                g.status  = RS_OK;
            end
            default:
            begin
                g.status = RS_OK;
            end
        endcase
        return g;
    endfunction

    function automatic void compare_field(string name, logic [ADDR_W-1:0] want,
                                          logic [ADDR_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // register writes, request beats and response beats, sampled at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_used  = '0;
            last_slot  = '0;
            reg_count  = COUNT_RESET;
            reg_base   = '0;
            reg_stride = STRIDE_RESET;
            grants_due.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SLOT_COUNT: reg_count  = cfg_data[COUNT_W-1:0];
                    CFG_HEAP_BASE:  reg_base   = cfg_data;
                    CFG_STRIDE:     reg_stride = cfg_data[STRIDE_W-1:0];
                    default:        ;
                endcase
            end
            if (req.valid && req.ready)
                grants_due.push_back(predict_grant(req.func, req.slot_index, req.handle_address));
            if (rsp.valid && rsp.ready)
            begin
                if (grants_due.size() == 0)
                begin
                    mismatches++;
                    $error("response beat with no request outstanding");
                end
                else
                begin
                    oldest = grants_due.pop_front();
                    compare_field("status", ADDR_W'(oldest.status), ADDR_W'(rsp.status));
                    compare_field("granted_index", ADDR_W'(oldest.index),
                                  ADDR_W'(rsp.granted_index));
                    compare_field("granted_address", oldest.address, rsp.granted_address);
                end
            end
            pending = grants_due.size();
        end
    end

endmodule

// File: tb/sv/tb_next_fit_slot_allocator.sv
// testbench top for the next-fit slot allocator: clock, reset, stimulus and verdict
module tb_next_fit_slot_allocator import nfsa_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 5;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_TAIL  = 80;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CALM_ITEMS   = 150;

    // register index the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [ADDR_W-1:0]    TOP_BASE  = 64'hFFFF_FFFF_FFFF_FFF0;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nfsa_req_if req ();
    nfsa_rsp_if rsp ();

    int fail_count;
    int grants_pending;

    // stimulus-side view of the pool settings
    int                pool_size  = MAX_SLOTS;
    logic [ADDR_W-1:0] base_now   = '0;
    logic [ADDR_W-1:0] stride_now = ADDR_W'(32);

    bit calm        = 1'b0;
    int random_sent = 0;
    int settings    = 0;
    int idle_cycles = 0;
    int beats_back  = 0;
    int full_beats  = 0;
    int range_beats = 0;

    next_fit_slot_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    nfsa_grant_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req            (req),
        .rsp            (rsp),
        .fail_count     (fail_count),
        .grants_pending (grants_pending)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // watchdog on cycles without any beat, plus response tallies
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rsp.valid && rsp.ready)
        begin
            beats_back++;
            if (rsp.status == RS_NO_FREE)
                full_beats++;
            if (rsp.status == RS_RANGE)
                range_beats++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // response side: random stall bursts, none once the run goes calm
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            repeat ($urandom_range(0, 30)) @(negedge clk);
        end
    end

    // one request beat; entered and left at a falling edge, valid kept high on exit
    task automatic send_req(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] idx,
                            logic [ADDR_W-1:0] addr);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        req.valid          <= 1'b1;
        req.func           <= func;
        req.slot_index     <= idx;
        req.handle_address <= addr;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop requesting and wait for every outstanding response
    task automatic drain();
        req.valid <= 1'b0;
        while (grants_pending != 0)
            @(negedge clk);
    endtask

    // new pool settings, written while the block is idle; upper data bits carry noise
    task automatic set_pool(logic [COUNT_W-1:0] count, logic [ADDR_W-1:0] base,
                            logic [STRIDE_W-1:0] stride);
        logic [CFG_DATA_W-1:0] data;
        drain();
        data                = {$urandom, $urandom};
        data[COUNT_W-1:0]   = count;
        cfg_we             <= 1'b1;
        cfg_index          <= CFG_SLOT_COUNT;
        cfg_data           <= data;
        @(negedge clk);
        cfg_index          <= CFG_HEAP_BASE;
        cfg_data           <= base;
        @(negedge clk);
        data                = {$urandom, $urandom};
        data[STRIDE_W-1:0]  = stride;
        cfg_index          <= CFG_STRIDE;
        cfg_data           <= data;
        @(negedge clk);
        cfg_index          <= CFG_SPARE;
        cfg_data           <= {$urandom, $urandom};
        @(negedge clk);
        cfg_we             <= 1'b0;
        pool_size  = (count == '0) ? 1 : ((count > COUNT_W'(MAX_SLOTS)) ? MAX_SLOTS : int'(count));
        base_now   = base;
        stride_now = (stride == '0) ? ADDR_W'(1) : ADDR_W'(stride);
        settings++;
    endtask

    // mostly well-formed allocs and frees inside the pool, with some noise
    task automatic random_item();
        int                pick;
        int                slot;
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, pool_size - 1);
        idx  = IDX_W'($urandom);
        addr = {$urandom, $urandom};
        if (pick < 45)
        begin
            func = $urandom_range(0, 1) ? FN_ALLOC_ADDR : FN_ALLOC_IDX;
        end
        else if (pick < 65)
        begin
            func = FN_FREE_IDX;
            if ($urandom_range(0, 4) != 0)
                idx = IDX_W'(slot);
        end
        else if (pick < 86)
        begin
            func = FN_FREE_ADDR;
            case ($urandom_range(0, 5))
                0:       ;
                1:       addr = base_now - ADDR_W'($urandom_range(1, 5000));
                2:       addr = base_now
                                + ADDR_W'($urandom_range(pool_size, MAX_SLOTS)) * stride_now;
                default: addr = base_now + ADDR_W'(slot) * stride_now
                                + ADDR_W'($urandom_range(0, int'(stride_now) - 1));
            endcase
        end
        else if (pick < 89)
        begin
            func = FN_CLEAR;
        end
        else
        begin
            func = FUNC_W'($urandom);
        end
        send_req(func, idx, addr);
    endtask

    task automatic run_phase(logic [COUNT_W-1:0] count, logic [ADDR_W-1:0] base,
                             logic [STRIDE_W-1:0] stride, int items);
        set_pool(count, base, stride);
        repeat (items)
        begin
            calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
            random_item();
            random_sent++;
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_SLOT_COUNT;
        cfg_data           = '0;
        req.valid          = 1'b0;
        req.func           = FN_ALLOC_IDX;
        req.slot_index     = '0;
        req.handle_address = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset settings, first grant lands after slot zero
        send_req(FN_ALLOC_IDX, '0, '0);
        send_req(FN_ALLOC_ADDR, '1, '1);
        send_req(FN_FREE_IDX, IDX_W'(1), '0);
        // freeing a slot that is already free
        send_req(FN_FREE_IDX, IDX_W'(1), '1);
        send_req(FN_FREE_IDX, '1, '0);
        // address inside a slot, not on its start
        send_req(FN_FREE_ADDR, '0, ADDR_W'(95));
        send_req(FN_FREE_ADDR, '0, '1);
        send_req(FN_CLEAR, '1, '1);
        for (int f = int'(FN_CLEAR) + 1; f < 2 ** FUNC_W; f++)
            send_req(FUNC_W'(f), '1, '1);
        send_req(FN_ALLOC_IDX, '0, '0);

        // directed: two slots near the top of the address space, widest stride
        set_pool(COUNT_W'(2), TOP_BASE, '1);
        repeat (3)
            send_req(FN_ALLOC_ADDR, '0, '0);
        send_req(FN_FREE_IDX, IDX_W'(1), '0);
        send_req(FN_FREE_IDX, IDX_W'(2), '0);
        // address below the base
        send_req(FN_FREE_ADDR, '0, TOP_BASE - ADDR_W'(1));
        // slot one wraps past the top of the address space
        send_req(FN_FREE_ADDR, '0, TOP_BASE + ADDR_W'(8191));
        send_req(FN_ALLOC_IDX, '0, '0);

        // random phases over a spread of pool settings
        run_phase(COUNT_W'(1),    '0,                 STRIDE_W'(1),    60);
        run_phase('0,             '1,                 '0,              60);
        run_phase(COUNT_W'(8),    {$urandom, $urandom}, '1,            100);
        run_phase(COUNT_W'(64),   {$urandom, $urandom}, STRIDE_W'(4096), 150);
        // count shrunk below slots still held
        run_phase(COUNT_W'(5),    {$urandom, $urandom},
                  STRIDE_W'($urandom_range(1, 4096)), 100);
        run_phase(COUNT_W'(1024), {$urandom, $urandom}, STRIDE_W'(32), 250);
        run_phase('1,             '0,
                  STRIDE_W'($urandom_range(1, 4096)), 150);
        run_phase(COUNT_W'(1025), {$urandom, $urandom}, STRIDE_W'(24), 100);
        run_phase(COUNT_W'(37),   TOP_BASE - ADDR_W'(100),
                  STRIDE_W'($urandom_range(1, 8191)), 230);

        drain();
        repeat (SETTLE_TAIL) @(negedge clk);

        $display("covered %0d responses over %0d pool settings", beats_back, settings);
        $display("%0d came back with no free slot, %0d out of range", full_beats, range_beats);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
